@@ src/hkc_pkg.sv @@
// shared types, constants and tables for the hls knn color cost block
package hkc_pkg;

   // field widths
   localparam int MODE_W      = 2;
   localparam int HUE_W       = 8;
   localparam int LUM_W       = 8;
   localparam int SAT_W       = 8;
   localparam int COST_W      = 7;
   localparam int NC_W        = 4;
   localparam int TOL_W       = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   // default sizes
   localparam int DEF_MAX_SAMPLES    = 128;
   localparam int DEF_MAX_NEIGHBOURS = 8;

   // item modes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEIGHBOUR_COUNT = 1'd0,
      CSR_KEEP_TOLERANCE  = 1'd1
   } csr_index_type;

   // one stored colour sample
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [LUM_W-1:0] lightness;
      logic [SAT_W-1:0] saturation;
   } sample_type;

   // register reset values
   localparam logic [NC_W-1:0]  NC_RESET  = 4'd1;
   localparam logic [TOL_W-1:0] TOL_RESET = 7'd7;

   // colour distance constants
   localparam logic [COST_W-1:0] SCORE_MAX   = 7'd90;
   localparam logic [HUE_W-1:0]  HUE_WRAP    = 8'd180;
   localparam logic [HUE_W-1:0]  HUE_HALF    = 8'd90;
   localparam logic [HUE_W-1:0]  HUE_NORM    = 8'd30;
   localparam logic [SAT_W-1:0]  FULL        = 8'd255;
   localparam logic [8:0]        SAT_SUM_MAX = 9'd510;

   // datapath widths of the score terms
   localparam int HD_W   = 5;
   localparam int SSUM_W = 9;
   localparam int H2_W   = 18;
   localparam int N3_W   = 26;

   // shared multiplier
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 21;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // score = floor(n3 / SCORE_DIV), done as reciprocal multiply plus one fix-up
   localparam logic [19:0] SCORE_DIV   = 20'd736950;
   localparam int          SCORE_SHIFT = 40;
   localparam logic [MUL_B_W-1:0] SCORE_RECIP =
      MUL_B_W'((64'd1 << SCORE_SHIFT) / 64'(SCORE_DIV));

   // ceil(2^16 / k) for k = 1..16, exact floor division for sums up to 90*k
   localparam int AVG_SHIFT   = 16;
   localparam int AVG_RECIP_W = 17;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP [16] = '{
      17'd65536, 17'd32768, 17'd21846, 17'd16384,
      17'd13108, 17'd10923, 17'd9363,  17'd8192,
      17'd7282,  17'd6554,  17'd5958,  17'd5462,
      17'd5042,  17'd4682,  17'd4370,  17'd4096
   };

endpackage

@@ src/hkc_if.sv @@
// valid/ready channel interfaces for request and response transactions
interface hkc_req_if
   import hkc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [HUE_W-1:0]  hue;
   logic [LUM_W-1:0]  lightness;
   logic [SAT_W-1:0]  saturation;

   modport source (output valid, mode, hue, lightness, saturation, input ready);
   modport sink   (input valid, mode, hue, lightness, saturation, output ready);
endinterface

interface hkc_rsp_if
   import hkc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] cost;
   logic              keep;

   modport source (output valid, cost, keep, input ready);
   modport sink   (input valid, cost, keep, output ready);
endinterface

@@ src/hkc_mul.sv @@
// shared registered multiplier for the score and averaging steps
module hkc_mul
   import hkc_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   // full-width product, registered
   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ src/hls_knn_color_cost_top.sv @@
// top level of the hls knn color cost block
//
//   channel   direction  handshake        payload
//   req_if    in         valid / ready    mode, hue, lightness, saturation
//   rsp_if    out        valid / ready    cost, keep
//   csr_*     in         csr_we only      csr_index, csr_wdata
//
// clear and append leave the input ready; after a query transaction the input stays busy
//   through the slot sweep, the scoring of each stored sample, any slot rescans and the
//   averaging, with each sample running the 11-step sequence through the shared multiplier.
// the sample store has no reset; only entries below the sample count are read.
// reset is synchronous, active high; the result waits in an output register,
//   and a later query holds in its last step until that register is taken.
module hls_knn_color_cost_top
   import hkc_pkg::*;
#(
   parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
   parameter int MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   hkc_req_if.sink                req_if,
   hkc_rsp_if.source              rsp_if
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int KW   = $clog2(MAX_NEIGHBOURS + 1);
   localparam int SW   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int SUMW = $clog2(int'(SCORE_MAX) * MAX_NEIGHBOURS + 1);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT,
      ST_FETCH,
      ST_DIFF,
      ST_MUL_SH,
      ST_MUL_LD,
      ST_MUL_SD,
      ST_MUL_H2,
      ST_NSUM,
      ST_MUL_REC,
      ST_QEST,
      ST_QFIX,
      ST_UPD,
      ST_SCAN,
      ST_SCAN_END,
      ST_SUM,
      ST_SUM_END,
      ST_AVG_MUL,
      ST_AVG_DONE,
      ST_OUT
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     idx_ff;
   logic [SW-1:0]     j_ff;
   logic [SW-1:0]     jp_ff;
   logic              rd_vld_ff;
   logic [SW-1:0]     worst_ff;
   logic [COST_W-1:0] wv_ff;
   logic [SUMW-1:0]   sum_ff;
   logic              rsp_valid_ff;
   logic [COST_W-1:0] rsp_cost_ff;
   logic              rsp_keep_ff;
   logic [COST_W-1:0] res_cost_ff;
   logic              res_keep_ff;

   // configuration
   logic [NC_W-1:0]   nc_ff;
   logic [TOL_W-1:0]  tol_ff;

   // datapath
   sample_type        query_ff;
   sample_type        samp_ff;
   logic [HD_W-1:0]   hd_ff;
   logic [LUM_W-1:0]  ld_ff;
   logic [SAT_W-1:0]  sd_ff;
   logic [SSUM_W-1:0] ssum_ff;
   logic [H2_W-1:0]   h2_ff;
   logic [N3_W-1:0]   n3_ff;
   logic [COST_W-1:0] q0_ff;
   logic [COST_W-1:0] score_ff;

   // memories
   sample_type        store_mem [MAX_SAMPLES];
   logic [COST_W-1:0] best_mem [MAX_NEIGHBOURS];
   logic [COST_W-1:0] slot_rd_ff;

   // combinational helpers
   logic               req_fire;
   sample_type         req_sample;
   logic               store_we;
   logic [KW-1:0]      k_eff;
   logic [SW-1:0]      k_last;
   logic [3:0]         recip_idx;
   logic               replace;
   logic               slot_we;
   logic [SW-1:0]      slot_wa;
   logic [COST_W-1:0]  slot_wd;
   logic [HUE_W-1:0]   hd_raw;
   logic [HUE_W-1:0]   hd_wrap;
   logic [HD_W-1:0]    hd_clip;
   logic [N3_W-1:0]    rem;
   logic [COST_W-1:0]  score_in;
   logic [COST_W-1:0]  avg_cost;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;

   // handshake and request decode
   assign req_fire              = req_if.valid && req_if.ready;
   assign req_if.ready          = (state_ff == ST_IDLE);
   assign req_sample.hue        = req_if.hue;
   assign req_sample.lightness  = req_if.lightness;
   assign req_sample.saturation = req_if.saturation;
   assign store_we = req_fire && (req_if.mode == MODE_APPEND) &&
                     (count_ff < CW'(MAX_SAMPLES));

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.cost  = rsp_cost_ff;
   assign rsp_if.keep  = rsp_keep_ff;

   // effective neighbour count, clamped to 1..MAX_NEIGHBOURS
   always_comb begin
      if (nc_ff == '0) begin
         k_eff = KW'(1);
      end else if ((NC_W + 1)'(nc_ff) > (NC_W + 1)'(MAX_NEIGHBOURS)) begin
         k_eff = KW'(MAX_NEIGHBOURS);
      end else begin
         k_eff = KW'(nc_ff);
      end
   end

   assign k_last    = SW'(k_eff - KW'(1));
   assign recip_idx = 4'(k_eff - KW'(1));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff  <= NC_RESET;
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_NEIGHBOUR_COUNT: nc_ff  <= csr_wdata[NC_W-1:0];
            CSR_KEEP_TOLERANCE:  tol_ff <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // sample store, one write and one registered read
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[AW-1:0]] <= req_sample;
      end
      if (state_ff == ST_FETCH) begin
         samp_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   // best score slots: sweep to 90, replace the worst slot
   assign replace = (state_ff == ST_UPD) && (score_ff < wv_ff);
   assign slot_we = (state_ff == ST_INIT) || replace;
   assign slot_wa = (state_ff == ST_INIT) ? j_ff : worst_ff;
   assign slot_wd = (state_ff == ST_INIT) ? SCORE_MAX : score_ff;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         best_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= best_mem[j_ff];
   end

   // wrapped and clamped hue distance
   always_comb begin
      hd_raw = (query_ff.hue > samp_ff.hue) ? query_ff.hue - samp_ff.hue
                                            : samp_ff.hue - query_ff.hue;
      if (hd_raw > HUE_HALF) begin
         hd_wrap = (hd_raw <= HUE_WRAP) ? HUE_WRAP - hd_raw : '0;
      end else begin
         hd_wrap = hd_raw;
      end
      hd_clip = (hd_wrap > HUE_NORM) ? HD_W'(HUE_NORM) : HD_W'(hd_wrap);
   end

   // quotient fix-up: add one when the remainder still holds a divisor, then clamp to SCORE_MAX
   always_comb begin
      rem      = n3_ff - prod[N3_W-1:0];
      score_in = q0_ff + COST_W'(rem >= N3_W'(SCORE_DIV));
      if (score_in > SCORE_MAX) begin
         score_in = SCORE_MAX;
      end
   end

   assign avg_cost = prod[AVG_SHIFT +: COST_W];

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_SH: begin
            mul_a = MUL_A_W'(ssum_ff);
            mul_b = MUL_B_W'(hd_ff);
         end
         ST_MUL_LD: begin
            mul_a = MUL_A_W'(SAT_SUM_MAX - ssum_ff);
            mul_b = MUL_B_W'(ld_ff);
         end
         ST_MUL_SD: begin
            mul_a = MUL_A_W'(sd_ff);
            mul_b = MUL_B_W'(sd_ff);
         end
         ST_MUL_H2: begin
            mul_a = MUL_A_W'(h2_ff);
            mul_b = MUL_B_W'(FULL - sd_ff);
         end
         ST_MUL_REC: begin
            mul_a = n3_ff;
            mul_b = SCORE_RECIP;
         end
         ST_QEST: begin
            mul_a = MUL_A_W'(prod[SCORE_SHIFT +: COST_W]);
            mul_b = MUL_B_W'(SCORE_DIV);
         end
         ST_AVG_MUL: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = MUL_B_W'(AVG_RECIP[recip_idx]);
         end
         default: ;
      endcase
   end

   hkc_mul u_hkc_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // score datapath, one term per step
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DIFF: begin
            hd_ff   <= hd_clip;
            ld_ff   <= (query_ff.lightness > samp_ff.lightness)
                       ? query_ff.lightness - samp_ff.lightness
                       : samp_ff.lightness - query_ff.lightness;
            sd_ff   <= (query_ff.saturation > samp_ff.saturation)
                       ? query_ff.saturation - samp_ff.saturation
                       : samp_ff.saturation - query_ff.saturation;
            ssum_ff <= SSUM_W'(query_ff.saturation) + SSUM_W'(samp_ff.saturation);
         end
         // 17 * S * hd
         ST_MUL_LD: h2_ff <= H2_W'({prod[13:0], 4'b0000}) + H2_W'(prod[13:0]);
         // plus 2 * (510 - S) * ld
         ST_MUL_SD: h2_ff <= h2_ff + H2_W'({prod[16:0], 1'b0});
         // 1020 * sd^2
         ST_MUL_H2: n3_ff <= N3_W'({prod[15:0], 10'b0}) - N3_W'({prod[15:0], 2'b00});
         // plus (255 - sd) * h2
         ST_NSUM:   n3_ff <= n3_ff + prod[N3_W-1:0];
         ST_QEST:   q0_ff <= prod[SCORE_SHIFT +: COST_W];
         ST_QFIX:   score_ff <= score_in;
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.mode == MODE_QUERY)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (j_ff == SW'(MAX_NEIGHBOURS - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:    state_in = (idx_ff == count_ff) ? ST_SUM : ST_DIFF;
         ST_DIFF:     state_in = ST_MUL_SH;
         ST_MUL_SH:   state_in = ST_MUL_LD;
         ST_MUL_LD:   state_in = ST_MUL_SD;
         ST_MUL_SD:   state_in = ST_MUL_H2;
         ST_MUL_H2:   state_in = ST_NSUM;
         ST_NSUM:     state_in = ST_MUL_REC;
         ST_MUL_REC:  state_in = ST_QEST;
         ST_QEST:     state_in = ST_QFIX;
         ST_QFIX:     state_in = ST_UPD;
         ST_UPD:      state_in = replace ? ST_SCAN : ST_FETCH;
         ST_SCAN: begin
            if (j_ff == k_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_FETCH;
         ST_SUM: begin
            if (j_ff == k_last) begin
               state_in = ST_SUM_END;
            end
         end
         ST_SUM_END:  state_in = ST_AVG_MUL;
         ST_AVG_MUL:  state_in = ST_AVG_DONE;
         ST_AVG_DONE: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer state, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN) || (state_ff == ST_SUM);
         jp_ff     <= j_ff;

         // taken response drops unless a new one loads in the same cycle
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (mode_type'(req_if.mode))
                     MODE_CLEAR:  count_ff <= '0;
                     MODE_APPEND: begin
                        if (store_we) begin
                           count_ff <= count_ff + CW'(1);
                        end
                     end
                     MODE_QUERY: begin
                        query_ff <= req_sample;
                        j_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_INIT: begin
               j_ff     <= j_ff + SW'(1);
               idx_ff   <= '0;
               worst_ff <= '0;
               wv_ff    <= SCORE_MAX;
            end
            ST_FETCH: begin
               if (idx_ff == count_ff) begin
                  j_ff   <= '0;
                  sum_ff <= '0;
               end
            end
            ST_UPD: begin
               if (replace) begin
                  j_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            ST_SCAN:     j_ff   <= j_ff + SW'(1);
            ST_SCAN_END: idx_ff <= idx_ff + CW'(1);
            ST_SUM:      j_ff   <= j_ff + SW'(1);
            ST_AVG_DONE: begin
               res_cost_ff <= avg_cost;
               res_keep_ff <= (avg_cost >= tol_ff);
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cost_ff  <= res_cost_ff;
                  rsp_keep_ff  <= res_keep_ff;
               end
            end
            default: ;
         endcase

         // rescan for the first largest slot after a replacement
         if (rd_vld_ff && ((state_ff == ST_SCAN) || (state_ff == ST_SCAN_END))) begin
            if ((jp_ff == '0) || (slot_rd_ff > wv_ff)) begin
               worst_ff <= jp_ff;
               wv_ff    <= slot_rd_ff;
            end
         end

         // add up the first k slots
         if (rd_vld_ff && ((state_ff == ST_SUM) || (state_ff == ST_SUM_END))) begin
            sum_ff <= sum_ff + SUMW'(slot_rd_ff);
         end
      end
   end

endmodule

@@ src/hkc_checker.sv @@
// port-level checks for the hls knn color cost block, bound to the top level
module hkc_checker
   import hkc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [MODE_W-1:0] req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COST_W-1:0] rsp_cost,
   input logic              rsp_keep
);

   // no response is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cost) && $stable(rsp_keep)))
      else $error("stalled response changed");

   // a query transaction keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_mode == MODE_QUERY)) |=> !req_ready)
      else $error("ready right after a query");

   // clear, append and unused modes leave the block ready on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_mode != MODE_QUERY)) |=> req_ready)
      else $error("busy after a store transaction");

   // cost never exceeds the score ceiling
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cost <= SCORE_MAX))
      else $error("cost out of range");

endmodule

bind hls_knn_color_cost_top hkc_checker u_hkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_mode  (req_if.mode),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_cost  (rsp_if.cost),
   .rsp_keep  (rsp_if.keep)
);

@@ bench/tb_top.sv @@
// testbench for the hls knn color cost block: scoreboard, channel drivers and stimulus
`timescale 1ns / 1ps

module tb_top;
   import hkc_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int STORE_DEPTH   = DEF_MAX_SAMPLES;
   localparam int SLOT_COUNT    = DEF_MAX_NEIGHBOURS;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 50000;
   localparam int SEGMENTS      = 9;
   localparam int SEGMENT_ITEMS = 80;
   localparam int BIG_FILL_MAX  = 5;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // one expected query result
   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              keep;
   } cost_result_type;

   // tracks the sample store and registers, predicts query results
   class cost_scoreboard;
      sample_type        samples [STORE_DEPTH];
      int unsigned       sample_total;
      logic [NC_W-1:0]   neighbours;
      logic [TOL_W-1:0]  tolerance;
      cost_result_type   pending_costs [$];
      int unsigned       failures;

      function new();
         sample_total = 0;
         neighbours   = NC_RESET;
         tolerance    = TOL_RESET;
         failures     = 0;
      endfunction

      function void write_register(input csr_index_type idx,
                                   input logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_NEIGHBOUR_COUNT: neighbours = value[NC_W-1:0];
            CSR_KEEP_TOLERANCE:  tolerance  = value[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      // exact integer form of floor(90 * blended hls distance)
      function logic [COST_W-1:0] colour_score(input sample_type q, input sample_type s);
         longint unsigned hd, ld, sd, ssum, hl, num, quo;
         longint unsigned full, norm, ssmax;
         full  = 64'(FULL);
         norm  = 64'(HUE_NORM);
         ssmax = 64'(SAT_SUM_MAX);
         hd   = (q.hue > s.hue) ? 64'(q.hue - s.hue) : 64'(s.hue - q.hue);
         ld   = (q.lightness > s.lightness) ? 64'(q.lightness - s.lightness)
                                            : 64'(s.lightness - q.lightness);
         sd   = (q.saturation > s.saturation) ? 64'(q.saturation - s.saturation)
                                              : 64'(s.saturation - q.saturation);
         ssum = longint'(q.saturation) + longint'(s.saturation);
         // hue wraps around the circle; out-of-range hues saturate to zero
         if (hd > HUE_HALF)
            hd = (hd <= HUE_WRAP) ? HUE_WRAP - hd : 0;
         if (hd > norm)
            hd = norm;
         hl  = ssum * hd * full + (ssmax - ssum) * ld * norm;
         num = sd * sd * (ssmax * norm * full) + (full - sd) * full * hl;
         // factor 3 is 90 / 30 folded into the numerator
         quo = (3 * num) / (ssmax * full * full * full);
         if (quo > SCORE_MAX)
            quo = 64'(SCORE_MAX);
         return quo[COST_W-1:0];
      endfunction

      // mean of the k smallest scores over the current store
      function cost_result_type nearest_cost(input sample_type q);
         int unsigned       k, worst, sum;
         logic [COST_W-1:0] slots [SLOT_COUNT];
         logic [COST_W-1:0] sc;
         cost_result_type   r;
         k = 32'(neighbours);
         if (k == 0)
            k = 1;
         if (k > SLOT_COUNT)
            k = SLOT_COUNT;
         foreach (slots[j])
            slots[j] = SCORE_MAX;
         worst = 0;
         for (int i = 0; i < sample_total; i++) begin
            sc = colour_score(q, samples[i]);
            // first largest slot is replaced only on a strictly smaller score
            if (sc < slots[worst]) begin
               slots[worst] = sc;
               worst = 0;
               for (int j = 1; j < k; j++)
                  if (slots[j] > slots[worst])
                     worst = j;
            end
         end
         sum = 0;
         for (int j = 0; j < k; j++)
            sum += 32'(slots[j]);
         r.cost = COST_W'(sum / k);
         r.keep = (r.cost >= tolerance);
         return r;
      endfunction

      function void note_request(input logic [MODE_W-1:0] mode, input sample_type colour);
         case (mode)
            MODE_CLEAR: sample_total = 0;
            MODE_APPEND: begin
               // appends past capacity are dropped
               if (sample_total < STORE_DEPTH) begin
                  samples[sample_total] = colour;
                  sample_total++;
               end
            end
            MODE_QUERY: pending_costs.insert(pending_costs.size(), nearest_cost(colour));
            default: ;
         endcase
      endfunction

      function void check_result(input logic [COST_W-1:0] cost, input logic keep);
         cost_result_type want;
         if (pending_costs.size() == 0) begin
            $error("unexpected result: cost %0d keep %0d", cost, keep);
            failures++;
            return;
         end
         want = pending_costs.pop_front();
         if (cost !== want.cost) begin
            $error("cost mismatch: expected %0d, actual %0d", want.cost, cost);
            failures++;
         end
         if (keep !== want.keep) begin
            $error("keep mismatch: expected %0d, actual %0d", want.keep, keep);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   hkc_req_if req_if ();
   hkc_rsp_if rsp_if ();

   cost_scoreboard board;
   int          req_idle_pct = 16;
   int          rsp_idle_pct = 81;
   int          stall_cycles = 0;
   int unsigned big_fills    = 0;
   sample_type  recent [$];

   hls_knn_color_cost_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // response backpressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // transaction monitor and stall counter
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            board.note_request(req_if.mode,
                               sample_type'({req_if.hue, req_if.lightness, req_if.saturation}));
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.cost, rsp_if.keep);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog
   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic sample_type make_colour(input logic [7:0] h, input logic [7:0] l,
                                               input logic [7:0] s);
      sample_type c;
      c.hue        = h;
      c.lightness  = l;
      c.saturation = s;
      return c;
   endfunction

   // mostly legal hues, some above the half-degree range
   function automatic sample_type random_colour();
      sample_type c;
      if ($urandom_range(0, 99) < 85)
         c.hue = HUE_W'($urandom_range(0, HUE_WRAP - 1));
      else
         c.hue = HUE_W'($urandom_range(HUE_WRAP, FULL));
      c.lightness  = LUM_W'($urandom_range(0, FULL));
      c.saturation = SAT_W'($urandom_range(0, FULL));
      return c;
   endfunction

   function automatic logic [7:0] nudge(input logic [7:0] v, input int spread);
      int t;
      t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
      if (t < 0)
         t = 0;
      if (t > int'(FULL))
         t = int'(FULL);
      return t[7:0];
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [MODE_W-1:0] mode, input sample_type c);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= mode;
      req_if.hue        <= c.hue;
      req_if.lightness  <= c.lightness;
      req_if.saturation <= c.saturation;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // drop valid, wait for every result, then let the block go idle
   task automatic settle();
      req_if.valid <= 1'b0;
      // let the monitor note the last transaction first
      @(posedge clock);
      while (board.pending_costs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] nc_value,
                            input logic [CSR_DATA_W-1:0] tol_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_NEIGHBOUR_COUNT;
      csr_wdata <= nc_value;
      @(posedge clock);
      board.write_register(CSR_NEIGHBOUR_COUNT, nc_value);
      csr_index <= CSR_KEEP_TOLERANCE;
      csr_wdata <= tol_value;
      @(posedge clock);
      board.write_register(CSR_KEEP_TOLERANCE, tol_value);
      csr_we <= 1'b0;
   endtask

   // store fills followed by queries, with some stray and unused-mode items
   task automatic run_mix(input int unsigned target);
      int unsigned       sent, n_append, n_query;
      sample_type        c, base;
      logic [MODE_W-1:0] m;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 99) < 8) begin
            m = MODE_W'($urandom_range(0, 3));
            c = random_colour();
            send_item(m, c);
            if (m != MODE_UNUSED)
               sent++;
            if (m == MODE_CLEAR)
               recent.delete();
            else if (m == MODE_APPEND)
               recent.insert(recent.size(), c);
         end else begin
            if ($urandom_range(0, 99) < 40) begin
               send_item(MODE_CLEAR, random_colour());
               recent.delete();
               sent++;
            end
            // rare fills can run past capacity
            if (big_fills < BIG_FILL_MAX && $urandom_range(0, 99) < 3) begin
               n_append = $urandom_range(STORE_DEPTH - 28, STORE_DEPTH + 12);
               big_fills++;
            end else begin
               n_append = $urandom_range(0, 10);
            end
            repeat (n_append) begin
               c = random_colour();
               send_item(MODE_APPEND, c);
               recent.insert(recent.size(), c);
               sent++;
            end
            n_query = $urandom_range(1, 4);
            repeat (n_query) begin
               // queries near a stored colour give small, close scores
               if (recent.size() != 0 && $urandom_range(0, 99) < 60) begin
                  base = recent[$urandom_range(0, recent.size() - 1)];
                  c = make_colour(nudge(base.hue, 6), nudge(base.lightness, 24),
                                  nudge(base.saturation, 24));
               end else begin
                  c = random_colour();
               end
               send_item(MODE_QUERY, c);
               sent++;
            end
         end
      end
   endtask

   initial begin
      board = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_NEIGHBOUR_COUNT;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_CLEAR;
      req_if.hue        <= '0;
      req_if.lightness  <= '0;
      req_if.saturation <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, exact match, field extremes, hue wrap and clamp
      send_item(MODE_QUERY,  make_colour(0, 0, 0));
      send_item(MODE_APPEND, make_colour(0, 0, 0));
      send_item(MODE_QUERY,  make_colour(0, 0, 0));
      send_item(MODE_APPEND, make_colour(179, 255, 255));
      send_item(MODE_APPEND, make_colour(255, 255, 0));
      send_item(MODE_APPEND, make_colour(90, 128, 128));
      send_item(MODE_QUERY,  make_colour(255, 0, 255));
      send_item(MODE_QUERY,  make_colour(200, 128, 128));
      send_item(MODE_UNUSED, make_colour(255, 255, 255));
      send_item(MODE_QUERY,  make_colour(89, 255, 0));
      // duplicate sample ties with an existing slot
      send_item(MODE_APPEND, make_colour(179, 255, 255));
      send_item(MODE_QUERY,  make_colour(179, 255, 255));
      send_item(MODE_CLEAR,  make_colour(0, 0, 0));
      send_item(MODE_QUERY,  make_colour(45, 100, 200));
      send_item(MODE_APPEND, make_colour(10, 20, 30));
      send_item(MODE_APPEND, make_colour(10, 20, 30));
      send_item(MODE_QUERY,  make_colour(12, 25, 28));
      send_item(MODE_QUERY,  make_colour(100, 200, 50));
      send_item(MODE_QUERY,  make_colour(134, 0, 255));
      settle();

      // random segments over several register settings and idle patterns
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 3)
            0: begin req_idle_pct = 16; rsp_idle_pct = 81; end
            1: begin req_idle_pct = 81; rsp_idle_pct = 16; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         case (seg)
            0: configure(8, 0);
            1: configure(15, 127);
            2: configure(0, 90);
            3: configure(3, 45);
            4: configure(1, 91);
            default: begin
               if ($urandom_range(0, 99) < 70)
                  configure(CSR_DATA_W'($urandom_range(1, SLOT_COUNT)),
                            CSR_DATA_W'($urandom_range(0, SCORE_MAX)));
               else
                  configure(CSR_DATA_W'($urandom_range(0, 127)),
                            CSR_DATA_W'($urandom_range(0, 127)));
            end
         endcase
         run_mix(SEGMENT_ITEMS);
         settle();
      end

      if (board.failures == 0 && board.pending_costs.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
